// ===== src/ffa_pkg.sv =====
// Package for the first-fit aligned allocator: types, sizes and codes.
// No dependencies.
`default_nettype none
package ffa_pkg;
    localparam int MAX_FREE_RANGES = 64;
    localparam int ADDR_BITS = 32;
    localparam int IDX_W = $clog2(MAX_FREE_RANGES);
    localparam int CNT_W = $clog2(MAX_FREE_RANGES + 1);
    localparam logic [ADDR_BITS-1:0] CAP_RESET = ADDR_BITS'(65536);

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_GROW  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_NOGROW = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]           command;
        logic [ADDR_BITS-1:0] block_offset;
        logic [ADDR_BITS-1:0] length;
        logic [4:0]           align_log2;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] alloc_offset;
        logic [ADDR_BITS-1:0] used_total;
        logic [6:0]           free_ranges;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIND_RD,
        S_FIND_CHK,
        S_PREV_RD,
        S_PREV_CHK,
        S_MERGE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_UP_WR,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

// ===== src/ffa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/first_fit_aligned_allocator_unit.sv =====
// First-fit aligned allocator: one transaction per start, result one cycle wide on done.
// Each scanned list entry takes a read state and a check state, each shifted entry a read
// and a write state; the worst case is a split allocate near a full list, and trivial commands go straight to S_DONE.
// Throughput: one transaction at a time; busy is high from acceptance through done,
// so the next start is taken in the cycle after done at the earliest.
// Reset: asynchronous; S_INIT then loads range [0,65536) into entry 0 while busy.
// Config writes reinitialize only in S_INIT/S_IDLE. Results cannot be stalled by the receiver.
// Depends on ffa_pkg and ffa_ram.
`default_nettype none
module first_fit_aligned_allocator_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire ffa_pkg::req_t                    req,
    output logic                                  done,
    output ffa_pkg::rsp_t                         rsp,
    input  wire logic                             cfg_we,
    input  wire logic [ffa_pkg::ADDR_BITS-1:0]    cfg_wdata
);
    import ffa_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int EW = 2 * AW;

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [AW-1:0]        cap_reg, cap_next;
    logic [AW-1:0]        used_reg, used_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]        ns_reg, ns_next;
    logic [AW-1:0]        nl_reg, nl_next;
    logic [AW-1:0]        pl_reg, pl_next;
    logic                 tn_reg, tn_next;
    logic                 alloc_reg, alloc_next;
    logic [1:0]           stat_reg, stat_next;
    logic [AW-1:0]        where_reg, where_next;
    logic [AW-1:0]        usize_reg, usize_next;
    logic [AW-1:0]        sub_reg, sub_next;

    // memory ports
    logic                 we;
    logic [IDX_W-1:0]     waddr, raddr;
    logic [EW-1:0]        wdata, rdata;
    logic [AW-1:0]        rd_s, rd_l;

    ffa_ram #(.WIDTH(EW), .DEPTH(MAX_FREE_RANGES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign rd_s = rdata[EW-1:AW];
    assign rd_l = rdata[AW-1:0];

    // fit arithmetic for the scan check: pad, rest test for the entry just read
    logic [AW-1:0] amask, pad, avail, rest;
    logic          fits;
    always_comb
    begin
        amask = (AW'(1) << req_reg.align_log2) - AW'(1);
        pad   = (AW'(0) - rd_s) & amask;
        avail = rd_l - pad;
        rest  = avail - req_reg.length;
        fits  = (rd_l >= pad) && (avail >= req_reg.length);
    end

    // state and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            count_reg <= CNT_W'(1);
            cap_reg   <= CAP_RESET;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        ptr_reg   <= ptr_next;
        ns_reg    <= ns_next;
        nl_reg    <= nl_next;
        pl_reg    <= pl_next;
        tn_reg    <= tn_next;
        alloc_reg <= alloc_next;
        stat_reg  <= stat_next;
        where_reg <= where_next;
        usize_reg <= usize_next;
        sub_reg   <= sub_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        ptr_next   = ptr_reg;
        ns_next    = ns_reg;
        nl_next    = nl_reg;
        pl_next    = pl_reg;
        tn_next    = tn_reg;
        alloc_next = alloc_reg;
        stat_next  = stat_reg;
        where_next = where_reg;
        usize_next = usize_reg;
        sub_next   = sub_reg;
        we    = 1'b0;
        waddr = idx_reg[IDX_W-1:0];
        wdata = '0;
        raddr = idx_reg[IDX_W-1:0];
        busy  = (state_reg != S_IDLE);
        done  = 1'b0;
        rsp   = '0;

        unique case (state_reg)
            // load entry 0 after reset
            S_INIT:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = {AW'(0), cap_reg};
                if (cfg_we)
                begin
                    cap_next   = cfg_wdata;
                    used_next  = '0;
                    count_next = (cfg_wdata != '0) ? CNT_W'(1) : '0;
                    wdata      = {AW'(0), cfg_wdata};
                end
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (cfg_we)
                begin
                    // reinitialize the list
                    cap_next   = cfg_wdata;
                    used_next  = '0;
                    count_next = (cfg_wdata != '0) ? CNT_W'(1) : '0;
                    we    = 1'b1;
                    waddr = '0;
                    wdata = {AW'(0), cfg_wdata};
                end
                else if (start)
                begin
                    req_next   = req;
                    stat_next  = ST_OK;
                    where_next = '0;
                    usize_next = '0;
                    sub_next   = '0;
                    alloc_next = 1'b0;
                    idx_next   = '0;
                    unique case (cmd_t'(req.command))
                        CMD_ALLOC: state_next = S_SCAN_RD;
                        CMD_FREE:
                        begin
                            if (req.length == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ns_next    = req.block_offset;
                                nl_next    = req.length;
                                sub_next   = req.length;
                                state_next = S_FIND_RD;
                            end
                        end
                        CMD_GROW:
                        begin
                            if (req.length <= cap_reg)
                            begin
                                stat_next  = ST_NOGROW;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ns_next    = cap_reg;
                                nl_next    = req.length - cap_reg;
                                state_next = S_FIND_RD;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            // first-fit scan: read entry idx
            S_SCAN_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    stat_next  = ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (!fits)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    where_next = rd_s + pad;
                    state_next = S_DONE;
                    if (req_reg.length != '0)
                    begin
                        usize_next = req_reg.length;
                        if (pad != '0 && rest != '0)
                        begin
                            if (count_reg >= CNT_W'(MAX_FREE_RANGES))
                            begin
                                where_next = '0;
                                usize_next = '0;
                                stat_next  = ST_FULL;
                            end
                            else
                            begin
                                // trim left piece, then insert right piece in order
                                we    = 1'b1;
                                wdata = {rd_s, pad};
                                ns_next    = rd_s + pad + req_reg.length;
                                nl_next    = rest;
                                alloc_next = 1'b1;
                                idx_next   = '0;
                                state_next = S_FIND_RD;
                            end
                        end
                        else if (pad != '0)
                        begin
                            we    = 1'b1;
                            wdata = {rd_s, pad};
                        end
                        else if (rest != '0)
                        begin
                            we    = 1'b1;
                            wdata = {rd_s + req_reg.length, rest};
                        end
                        else
                        begin
                            // remove entry: shift down
                            ptr_next   = idx_reg;
                            tn_next    = 1'b0;
                            state_next = S_SHIFT_RD;
                        end
                    end
                end
            end

            // sorted position search for ns
            S_FIND_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    tn_next    = 1'b0;
                    state_next = S_PREV_RD;
                end
                else
                begin
                    state_next = S_FIND_CHK;
                end
            end

            S_FIND_CHK:
            begin
                if (ns_reg < rd_s)
                begin
                    tn_next    = ((ns_reg + nl_reg) == rd_s) && !alloc_reg;
                    pl_next    = rd_l;
                    state_next = S_PREV_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_FIND_RD;
                end
            end

            // read the predecessor; pl holds the successor's length for now
            S_PREV_RD:
            begin
                usize_next = pl_reg;
                raddr      = IDX_W'(idx_reg - CNT_W'(1));
                state_next = S_PREV_CHK;
            end

            S_PREV_CHK:
            begin
                pl_next = rd_l;
                if (!alloc_reg && idx_reg != '0 && (rd_s + rd_l) == ns_reg)
                begin
                    if (tn_reg)
                    begin
                        // merge all three, remove successor
                        we    = 1'b1;
                        waddr = IDX_W'(idx_reg - CNT_W'(1));
                        wdata = {rd_s, rd_l + nl_reg + usize_reg};
                        ptr_next   = idx_reg;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        we    = 1'b1;
                        waddr = IDX_W'(idx_reg - CNT_W'(1));
                        wdata = {rd_s, rd_l + nl_reg};
                        state_next = S_MERGE;
                    end
                end
                else if (tn_reg)
                begin
                    we    = 1'b1;
                    wdata = {ns_reg, usize_reg + nl_reg};
                    state_next = S_MERGE;
                end
                else if (count_reg >= CNT_W'(MAX_FREE_RANGES))
                begin
                    usize_next = '0;
                    stat_next  = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    // make room: shift entries up from the end
                    ptr_next   = count_reg;
                    state_next = S_PLACE;
                end
            end

            // finish a transaction that changed the list
            S_MERGE:
            begin
                state_next = S_DONE;
                if (alloc_reg || cmd_t'(req_reg.command) == CMD_ALLOC)
                begin
                    usize_next = req_reg.length;
                end
                else
                begin
                    usize_next = '0;
                    if (cmd_t'(req_reg.command) == CMD_GROW)
                    begin
                        cap_next = req_reg.length;
                    end
                    else
                    begin
                        used_next = (used_reg > sub_reg) ? used_reg - sub_reg : '0;
                    end
                end
            end

            // remove entry at ptr by shifting ptr+1.. down
            S_SHIFT_RD:
            begin
                if (ptr_reg + CNT_W'(1) >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_MERGE;
                end
                else
                begin
                    raddr      = IDX_W'(ptr_reg + CNT_W'(1));
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                we    = 1'b1;
                waddr = ptr_reg[IDX_W-1:0];
                wdata = rdata;
                ptr_next   = ptr_reg + CNT_W'(1);
                state_next = S_SHIFT_RD;
            end

            // insert at idx: move ptr-1 to ptr until ptr reaches idx
            S_PLACE:
            begin
                if (ptr_reg == idx_reg)
                begin
                    we    = 1'b1;
                    waddr = idx_reg[IDX_W-1:0];
                    wdata = {ns_reg, nl_reg};
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_MERGE;
                end
                else
                begin
                    raddr      = IDX_W'(ptr_reg - CNT_W'(1));
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                we    = 1'b1;
                waddr = ptr_reg[IDX_W-1:0];
                wdata = rdata;
                ptr_next   = ptr_reg - CNT_W'(1);
                state_next = S_PLACE;
            end

            S_DONE:
            begin
                done = 1'b1;
                rsp.status       = stat_reg;
                rsp.alloc_offset = where_reg;
                rsp.used_total   = used_reg + usize_reg;
                rsp.free_ranges  = 7'(count_reg);
                used_next  = used_reg + usize_reg;
                usize_next = '0;
                state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== verif/tb_first_fit_aligned_allocator_unit.sv =====
// Testbench for first_fit_aligned_allocator_unit: directed and random allocate, free and grow
// transactions checked against an in-bench free-list predictor. Depends on ffa_pkg and the RTL.
`timescale 1ns / 100ps
module tb_first_fit_aligned_allocator_unit;
    import ffa_pkg::*;

    localparam int  NR = MAX_FREE_RANGES;
    localparam int  LIMIT = 1_500_000;
    localparam int  DRAIN = 4 * MAX_FREE_RANGES + 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    req_t                 req = '0;
    logic                 done;
    rsp_t                 rsp;
    logic                 cfg_we = 1'b0;
    logic [ADDR_BITS-1:0] cfg_wdata = '0;

    first_fit_aligned_allocator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Free-list shadow
    logic [31:0] fl_start [NR];
    logic [31:0] fl_len [NR];
    int          fl_cnt;
    logic [31:0] cap_now;
    logic [31:0] bytes_used;

    req_t        pend_q [$];
    rsp_t        want_q [$];
    logic [31:0] live_off [$];
    logic [31:0] live_len [$];
    int          idle_pct = 0;
    int          errors = 0;
    int          cycles = 0;
    bit          taken = 1'b0;

    function automatic void list_init(logic [31:0] cap);
        for (int k = 0; k < NR; k++)
        begin
            fl_start[k] = '0;
            fl_len[k] = '0;
        end
        cap_now = cap;
        bytes_used = '0;
        fl_cnt = 0;
        if (cap != 0)
        begin
            fl_len[0] = cap;
            fl_cnt = 1;
        end
    endfunction

    function automatic void list_insert(int idx, logic [31:0] s, logic [31:0] l);
        if (fl_cnt >= NR || idx > fl_cnt)
            return;
        for (int k = fl_cnt; k > idx; k--)
        begin
            fl_start[k] = fl_start[k-1];
            fl_len[k] = fl_len[k-1];
        end
        fl_start[idx] = s;
        fl_len[idx] = l;
        fl_cnt++;
    endfunction

    function automatic void list_remove(int idx);
        if (idx >= fl_cnt)
            return;
        for (int k = idx; k + 1 < fl_cnt; k++)
        begin
            fl_start[k] = fl_start[k+1];
            fl_len[k] = fl_len[k+1];
        end
        fl_cnt--;
        fl_start[fl_cnt] = '0;
        fl_len[fl_cnt] = '0;
    endfunction

    function automatic int slot_for(logic [31:0] s);
        int i;
        i = 0;
        while (i < fl_cnt && !(s < fl_start[i]))
            i++;
        return i;
    endfunction

    // Insert a range in order and merge exactly touching neighbors
    function automatic status_t give_back(logic [31:0] s, logic [31:0] l);
        int idx;
        bit tp;
        bit tn;
        idx = slot_for(s);
        tp = idx > 0 && (fl_start[idx-1] + fl_len[idx-1]) == s;
        tn = idx < fl_cnt && (s + l) == fl_start[idx];
        if (tp && tn)
        begin
            fl_len[idx-1] = fl_len[idx-1] + l + fl_len[idx];
            list_remove(idx);
        end
        else if (tp)
            fl_len[idx-1] = fl_len[idx-1] + l;
        else if (tn)
        begin
            fl_start[idx] = s;
            fl_len[idx] = fl_len[idx] + l;
        end
        else
        begin
            if (fl_cnt >= NR)
                return ST_FULL;
            list_insert(idx, s, l);
        end
        return ST_OK;
    endfunction

    // First fit with aligned start
    function automatic status_t carve(logic [31:0] size, logic [4:0] al,
                                      output logic [31:0] at);
        logic [31:0] amask;
        logic [31:0] s;
        logic [31:0] l;
        logic [31:0] pad;
        logic [31:0] rest;
        amask = (32'd1 << al) - 32'd1;
        at = '0;
        for (int i = 0; i < fl_cnt; i++)
        begin
            s = fl_start[i];
            l = fl_len[i];
            pad = (32'd0 - s) & amask;
            if (l < pad || l - pad < size)
                continue;
            rest = l - pad - size;
            at = s + pad;
            if (size == 0)
                return ST_OK;
            if (pad > 0 && rest > 0)
            begin
                if (fl_cnt >= NR)
                begin
                    at = '0;
                    return ST_FULL;
                end
                fl_len[i] = pad;
                list_insert(slot_for(s + pad + size), s + pad + size, rest);
            end
            else if (pad > 0)
                fl_len[i] = pad;
            else if (rest > 0)
            begin
                fl_start[i] = s + size;
                fl_len[i] = rest;
            end
            else
                list_remove(i);
            bytes_used = bytes_used + size;
            return ST_OK;
        end
        return ST_NOFIT;
    endfunction

    function automatic rsp_t allocator_step(req_t r);
        rsp_t        o;
        status_t     st;
        logic [31:0] at;
        st = ST_OK;
        at = '0;
        case (cmd_t'(r.command))
            CMD_ALLOC:
            begin
                st = carve(r.length, r.align_log2, at);
                if (st == ST_OK && r.length != 0)
                begin
                    live_off.push_back(at);
                    live_len.push_back(r.length);
                end
            end
            CMD_FREE:
                if (r.length != 0)
                begin
                    st = give_back(r.block_offset, r.length);
                    if (st == ST_OK)
                        bytes_used = bytes_used > r.length ? bytes_used - r.length : '0;
                end
            CMD_GROW:
                if (r.length <= cap_now)
                    st = ST_NOGROW;
                else
                begin
                    st = give_back(cap_now, r.length - cap_now);
                    if (st == ST_OK)
                        cap_now = r.length;
                end
            default: ;
        endcase
        o.status = st;
        o.alloc_offset = at;
        o.used_total = bytes_used;
        o.free_ranges = 7'(fl_cnt);
        return o;
    endfunction

    task automatic queue_req(cmd_t c, logic [31:0] off, logic [31:0] len, logic [4:0] al);
        req_t r;
        r.command = c;
        r.block_offset = off;
        r.length = len;
        r.align_log2 = al;
        pend_q.push_back(r);
    endtask

    // Mostly well-formed traffic: allocations and frees of live blocks, plus noise
    task automatic queue_random();
        int          pick;
        int          j;
        logic [31:0] len;
        pick = $urandom_range(99);
        wait (pend_q.size() == 0);
        if (pick >= 45 && pick < 80 && live_off.size() > 0)
        begin
            j = $urandom_range(live_off.size() - 1);
            queue_req(CMD_FREE, live_off[j], live_len[j], 5'($urandom));
            live_off.delete(j);
            live_len.delete(j);
        end
        else if (pick >= 80 && pick < 85)
        begin
            len = ($urandom_range(3) == 0) ? $urandom : cap_now + $urandom_range(0, 4096);
            queue_req(CMD_GROW, $urandom, len, 5'($urandom));
        end
        else if (pick >= 85 && pick < 95)
            queue_req(cmd_t'($urandom_range(3)), $urandom,
                      ($urandom_range(1) != 0) ? $urandom : $urandom_range(0, 2048),
                      5'($urandom));
        else if (pick >= 95 && live_off.size() > 0)
        begin
            // partial or shifted free of a live block
            j = $urandom_range(live_off.size() - 1);
            queue_req(CMD_FREE, live_off[j] + $urandom_range(0, 3),
                      $urandom_range(0, live_len[j]), 5'd0);
        end
        else
        begin
            len = ($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 700);
            queue_req(CMD_ALLOC, $urandom, len,
                      ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6)));
        end
    endtask

    task automatic wait_idle();
        wait (pend_q.size() == 0 && !start && want_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_capacity(logic [31:0] v);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Driver: new transaction or idle at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!start || taken))
        begin
            taken = 1'b0;
            if (pend_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                req <= pend_q.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: acceptance, configuration writes and result checks
    always @(posedge clk)
    begin
        rsp_t w;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (want_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, rsp);
                    errors++;
                end
                else
                begin
                    w = want_q.pop_front();
                    if (rsp.status !== w.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, w.status, rsp.status);
                        errors++;
                    end
                    if (rsp.alloc_offset !== w.alloc_offset)
                    begin
                        $display("%0t: alloc_offset exp %h got %h", $time,
                                 w.alloc_offset, rsp.alloc_offset);
                        errors++;
                    end
                    if (rsp.used_total !== w.used_total)
                    begin
                        $display("%0t: used_total exp %h got %h", $time,
                                 w.used_total, rsp.used_total);
                        errors++;
                    end
                    if (rsp.free_ranges !== w.free_ranges)
                    begin
                        $display("%0t: free_ranges exp %0d got %0d", $time,
                                 w.free_ranges, rsp.free_ranges);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                list_init(cfg_wdata);
                live_off.delete();
                live_len.delete();
            end
            if (start && !busy)
            begin
                want_q.push_back(allocator_step(req));
                taken = 1'b1;
            end
        end
    end

    initial
    begin
        logic [31:0] caps [6];
        caps = '{32'h0, 32'hFFFF_FFFF, 32'd4096, 32'd300, 32'h0001_0000, 32'h0};
        list_init(CAP_RESET);
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, each command, zero sizes, grow cases, big alignment
        queue_req(CMD_ALLOC, '0, 32'd0, 5'd0);
        queue_req(CMD_ALLOC, '0, 32'd1, 5'd31);
        queue_req(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        queue_req(CMD_ALLOC, '0, 32'd100, 5'd0);
        queue_req(CMD_ALLOC, '0, 32'd10, 5'd8);
        queue_req(CMD_ALLOC, '0, 32'd0, 5'd12);
        queue_req(CMD_FREE, 32'd300, 32'd0, 5'd0);
        queue_req(CMD_FREE, 32'd0, 32'd100, 5'd0);
        queue_req(CMD_FREE, 32'd256, 32'd10, 5'd0);
        queue_req(CMD_FREE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 5'd31);
        queue_req(CMD_GROW, '0, 32'd1000, 5'd0);
        queue_req(CMD_GROW, '0, 32'h0002_0000, 5'd0);
        queue_req(CMD_GROW, '0, 32'hFFFF_FFFF, 5'd31);
        queue_req(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        queue_req(CMD_ALLOC, '0, 32'h0001_0000, 5'd16);
        queue_req(CMD_ALLOC, '0, 32'd64, 5'd30);
        // fragment the list: aligned grants leave a pad and a tail
        for (int k = 0; k < 8; k++)
            queue_req(CMD_ALLOC, '0, 32'd3, 5'd4);

        // Random phases over capacity settings and idle rates
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 82 : 38);
            for (int n = 0; n < 205; n++)
                queue_random();
            write_capacity((ph == 5) ? $urandom : caps[ph]);
        end
        for (int n = 0; n < 40; n++)
            queue_random();

        wait_idle();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
